@@ hw/rtl/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg: shared types and constants of the block pool allocator
// Request and response payloads, configuration record, operation and
// register codes, and the command/status records between the controller
// and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

	// Field widths.
	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 16;
	localparam int CNT_W      = 9;
	localparam int STAT_W     = 32;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Divider geometry for the release offset check.
	localparam int DIV_STEPS = ADDR_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// Operation codes.
	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_INIT    = 2'd2;
	localparam logic [1:0] OP_CLEAR   = 2'd3;

	// Register indexes (byte address is four times the index).
	localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_MAX_REQUEST  = 2'd1;
	localparam logic [1:0] REG_SLOT_STRIDE  = 2'd2;
	localparam logic [1:0] REG_SLOT_COUNT   = 2'd3;

	// Register reset values.
	localparam logic [ADDR_W-1:0] RST_BASE_ADDRESS = 32'd0;
	localparam logic [SIZE_W-1:0] RST_MAX_REQUEST  = 16'd64;
	localparam logic [SIZE_W-1:0] RST_SLOT_STRIDE  = 16'd64;
	localparam logic [CNT_W-1:0]  RST_SLOT_COUNT   = 9'd256;

	typedef struct packed {
		logic [ADDR_W-1:0] base_address;
		logic [SIZE_W-1:0] max_request_size;
		logic [SIZE_W-1:0] slot_stride;
		logic [CNT_W-1:0]  slot_count;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [SIZE_W-1:0] request_size;
		logic [ADDR_W-1:0] release_address;
	} req_t;

	typedef struct packed {
		logic              success;
		logic [ADDR_W-1:0] slot_address;
		logic [CNT_W-1:0]  free_slots;
		logic [CNT_W-1:0]  peak_in_use;
		logic [STAT_W-1:0] fragmentation_total;
		logic [STAT_W-1:0] allocation_total;
	} rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic latch;       // capture the accepted request
		logic rd_head;     // read the free-list head entry, form the slot offset
		logic rd_pos;      // read the entry at the divided release position
		logic div_start;   // start the offset divider
		logic sweep_step;  // write one entry of the pool sweep
		logic commit;      // apply the operation and load the response
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic sweep_last;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/fbpa_regs.sv @@
// ----------------------------------------------------------------------------
// fbpa_regs: configuration register file
// APB-style slave holding base address, request limit, slot stride and
// slot count. Zero wait states; reads return the stored values.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fbpa_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [fbpa_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [fbpa_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	output fbpa_pkg::cfg_t                    cfg
);
	import fbpa_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_address     <= RST_BASE_ADDRESS;
			cfg_q.max_request_size <= RST_MAX_REQUEST;
			cfg_q.slot_stride      <= RST_SLOT_STRIDE;
			cfg_q.slot_count       <= RST_SLOT_COUNT;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BASE_ADDRESS: cfg_q.base_address     <= pwdata;
				REG_MAX_REQUEST:  cfg_q.max_request_size <= pwdata[SIZE_W-1:0];
				REG_SLOT_STRIDE:  cfg_q.slot_stride      <= pwdata[SIZE_W-1:0];
				REG_SLOT_COUNT:   cfg_q.slot_count       <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		case (reg_idx)
			REG_BASE_ADDRESS: prdata = cfg_q.base_address;
			REG_MAX_REQUEST:  prdata = APB_DATA_W'(cfg_q.max_request_size);
			REG_SLOT_STRIDE:  prdata = APB_DATA_W'(cfg_q.slot_stride);
			REG_SLOT_COUNT:   prdata = APB_DATA_W'(cfg_q.slot_count);
			default:          prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/fbpa_div.sv @@
// ----------------------------------------------------------------------------
// fbpa_div: iterative offset divider
// Restoring division of a 32-bit offset by the 16-bit slot stride, one
// quotient bit per cycle. Results hold until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fbpa_pkg::ADDR_W-1:0]   dividend,
	input  logic [fbpa_pkg::SIZE_W-1:0]   divisor,
	output logic                          done,
	output logic [fbpa_pkg::ADDR_W-1:0]   quotient,
	output logic [fbpa_pkg::SIZE_W-1:0]   remainder
);
	import fbpa_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [ADDR_W-1:0]    quot_q;
	logic [SIZE_W-1:0]    rem_q;
	logic [SIZE_W-1:0]    divisor_q;
	logic [SIZE_W+1:0]    trial;

	assign done = (cnt_q == DIV_CNT_W'(DIV_STEPS));

	// Shift in the next dividend bit and try to subtract the divisor.
	assign trial = {1'b0, rem_q, quot_q[ADDR_W-1]} - {2'b00, divisor_q};

	// Step counter; it idles at the final count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= DIV_CNT_W'(DIV_STEPS);
		end else if (start) begin
			cnt_q <= '0;
		end else if (!done) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (!done) begin
			if (!trial[SIZE_W+1]) begin
				rem_q <= trial[SIZE_W-1:0];
			end else begin
				rem_q <= {rem_q[SIZE_W-2:0], quot_q[ADDR_W-1]};
			end
			quot_q <= {quot_q[ADDR_W-2:0], ~trial[SIZE_W+1]};
		end
	end

	assign quotient  = quot_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

@@ hw/rtl/fbpa_dp.sv @@
// ----------------------------------------------------------------------------
// fbpa_dp: allocator datapath
// Link/busy memory, free-list head and counters, statistics, the sweep
// counter, the offset divider and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_dp #(
	parameter int MAX_SLOTS = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fbpa_pkg::cfg_t  cfg,
	input  fbpa_pkg::req_t  req_data,
	input  fbpa_pkg::cmd_t  cmd,
	output fbpa_pkg::sts_t  sts,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output fbpa_pkg::rsp_t  rsp_data
);
	import fbpa_pkg::*;

	localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int WORD_W = IDX_W + 1;
	localparam int PROD_W = IDX_W + SIZE_W;

	// Each memory word holds the busy bit over the next-free link.
	logic [WORD_W-1:0] pool_mem_q [MAX_SLOTS];
	logic [WORD_W-1:0] rd_word_q;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	logic [WORD_W-1:0] mem_wd;
	logic [IDX_W-1:0]  mem_ra;

	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  free_count_q;
	logic [CNT_W-1:0]  peak_q;
	logic [STAT_W-1:0] frag_q;
	logic [STAT_W-1:0] grant_q;
	logic [IDX_W-1:0]  sweep_cnt_q;
	logic [1:0]        op_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PROD_W-1:0] prod_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [CNT_W-1:0]  eff_count;
	logic [IDX_W-1:0]  link_init;
	logic [IDX_W-1:0]  alloc_link;
	logic [IDX_W-1:0]  rel_pos;
	logic              alloc_grant;
	logic              rel_ok;
	logic              div_done;
	logic [ADDR_W-1:0] div_quot;
	logic [SIZE_W-1:0] div_rem;

	logic [IDX_W-1:0]  head_d;
	logic [CNT_W-1:0]  free_count_d;
	logic [CNT_W-1:0]  peak_d;
	logic [STAT_W-1:0] frag_d;
	logic [STAT_W-1:0] grant_d;
	logic [CNT_W-1:0]  in_use;
	rsp_t              rsp_d;

	// Slot count in use, saturated at the pool capacity.
	assign eff_count = (32'(cfg.slot_count) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS)
	                                                     : cfg.slot_count;

	// Sweep link: slot i points to i+1, the last slot in use points to zero.
	assign link_init = ((32'(sweep_cnt_q) + 32'd1) < 32'(eff_count))
	                   ? sweep_cnt_q + IDX_W'(1) : '0;

	// Offset divider for release checks.
	fbpa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (req_data.release_address - cfg.base_address),
		.divisor   (cfg.slot_stride),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	assign alloc_link = rd_word_q[IDX_W-1:0];
	assign rel_pos    = div_quot[IDX_W-1:0];

	assign alloc_grant = (op_q == OP_ALLOC) && (size_q <= cfg.max_request_size)
	                     && (free_count_q != '0);
	assign rel_ok      = (op_q == OP_RELEASE) && (cfg.slot_stride != '0)
	                     && (addr_q >= cfg.base_address) && (div_rem == '0)
	                     && (div_quot < 32'(eff_count)) && rd_word_q[IDX_W];

	// Request capture and slot offset product.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= req_data.operation;
			size_q <= req_data.request_size;
			addr_q <= req_data.release_address;
		end
		if (cmd.rd_head) begin
			prod_q <= head_q * cfg.slot_stride;
		end
	end

	// Memory ports: one write, one registered read.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = sweep_cnt_q;
		mem_wd = {1'b0, link_init};
		if (cmd.sweep_step) begin
			mem_we = 1'b1;
		end else if (cmd.commit && alloc_grant) begin
			mem_we = 1'b1;
			mem_wa = head_q;
			mem_wd = {1'b1, alloc_link};
		end else if (cmd.commit && rel_ok) begin
			mem_we = 1'b1;
			mem_wa = rel_pos;
			mem_wd = {1'b0, head_q};
		end
	end

	assign mem_ra = cmd.rd_pos ? rel_pos : head_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pool_mem_q[mem_wa] <= mem_wd;
		end
		if (cmd.rd_head || cmd.rd_pos) begin
			rd_word_q <= pool_mem_q[mem_ra];
		end
	end

	// Sweep counter, shared by the clearing pass and initialize.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_cnt_q <= '0;
		end else if (cmd.sweep_step) begin
			sweep_cnt_q <= sts.sweep_last ? '0 : sweep_cnt_q + IDX_W'(1);
		end
	end

	// Next pool state and response for the operation being finished.
	always_comb begin
		head_d       = head_q;
		free_count_d = free_count_q;
		peak_d       = peak_q;
		frag_d       = frag_q;
		grant_d      = grant_q;
		in_use       = '0;
		rsp_d.success      = 1'b1;
		rsp_d.slot_address = '0;
		case (op_q)
			OP_ALLOC: begin
				rsp_d.success = alloc_grant;
				if (alloc_grant) begin
					rsp_d.slot_address = cfg.base_address + ADDR_W'(prod_q);
					head_d       = alloc_link;
					free_count_d = free_count_q - 1'b1;
					frag_d  = frag_q + (STAT_W'(cfg.max_request_size) - STAT_W'(size_q));
					grant_d = grant_q + 1'b1;
					in_use  = (eff_count > free_count_d) ? eff_count - free_count_d : '0;
					if (in_use > peak_q) begin
						peak_d = in_use;
					end
				end
			end
			OP_RELEASE: begin
				rsp_d.success = rel_ok;
				if (rel_ok) begin
					head_d       = rel_pos;
					free_count_d = free_count_q + 1'b1;
				end
			end
			OP_INIT: begin
				head_d       = '0;
				free_count_d = eff_count;
				peak_d       = '0;
				frag_d       = '0;
				grant_d      = '0;
			end
			default: begin
				peak_d  = '0;
				frag_d  = '0;
				grant_d = '0;
			end
		endcase
		rsp_d.free_slots          = free_count_d;
		rsp_d.peak_in_use         = peak_d;
		rsp_d.fragmentation_total = frag_d;
		rsp_d.allocation_total    = grant_d;
	end

	// Pool state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			free_count_q <= '0;
			peak_q       <= '0;
			frag_q       <= '0;
			grant_q      <= '0;
		end else if (cmd.commit) begin
			head_q       <= head_d;
			free_count_q <= free_count_d;
			peak_q       <= peak_d;
			frag_q       <= frag_d;
			grant_q      <= grant_d;
		end
	end

	// Response register: loaded on commit, freed when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign sts.sweep_last = (sweep_cnt_q == IDX_W'(MAX_SLOTS - 1));
	assign sts.div_done   = div_done;
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;

	// The free count never exceeds the pool capacity.
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(free_count_q) <= MAX_SLOTS)
		else $error("free count above pool capacity");

	// A new response appears only through a commit.
	a_rsp_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(cmd.commit))
		else $error("response raised without commit");

	// Every granted allocation advances the grant counter by one.
	a_grant_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && alloc_grant |=> grant_q == $past(grant_q) + 32'd1)
		else $error("grant counter missed a granted allocation");

endmodule

`default_nettype wire

@@ hw/rtl/fbpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbpa_ctrl: allocator controller
// Sequences the clearing pass after reset and each request through the
// datapath: head read, divide and position read, pool sweep or none, then commit.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic [1:0]      operation,
	output logic            req_stall,
	input  fbpa_pkg::sts_t  sts,
	output fbpa_pkg::cmd_t  cmd
);
	import fbpa_pkg::*;

	localparam logic [2:0] S_CLEAR_PASS = 3'd0;
	localparam logic [2:0] S_IDLE       = 3'd1;
	localparam logic [2:0] S_SWEEP      = 3'd2;
	localparam logic [2:0] S_DIV        = 3'd3;
	localparam logic [2:0] S_REL_RD     = 3'd4;
	localparam logic [2:0] S_FINISH     = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_stall = (state_q != S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR_PASS: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					case (operation)
						OP_ALLOC: begin
							cmd.rd_head = 1'b1;
							state_d     = S_FINISH;
						end
						OP_RELEASE: begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end
						OP_INIT: state_d = S_SWEEP;
						default: state_d = S_FINISH;
					endcase
				end
			end
			S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_FINISH;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_REL_RD;
				end
			end
			S_REL_RD: begin
				cmd.rd_pos = 1'b1;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR_PASS;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/fixed_block_pool_allocator_core.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core: fixed-size block pool allocator
// Equal-sized slots tracked by a linked free list and per-slot busy bits,
// with allocate, release, initialize and clear-statistics requests.
//
//   channel  | flow | handshake                  | payload
//   ---------+------+----------------------------+------------------
//   req      | in   | req_valid / req_stall      | fbpa_pkg::req_t
//   rsp      | out  | rsp_valid / rsp_stall      | fbpa_pkg::rsp_t
//   apb      | in   | psel, penable, pready      | paddr/pwdata/prdata
//
// Allocate and clear statistics: the request is taken, and it commits once the
// response register is free (for allocate, the registered link read lands first).
// Release: the stride divider retires one quotient bit per cycle, the
// controller sees it finish, then the busy/link entry is read and the request
// commits.
// Initialize sweeps every memory entry, one entry swept per cycle, then commits.
// After reset a clearing pass over every memory entry holds req_stall high.
// A finished response waits in its register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator_core #(
	parameter int MAX_SLOTS = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  fbpa_pkg::req_t                    req_data,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output fbpa_pkg::rsp_t                    rsp_data,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fbpa_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [fbpa_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [fbpa_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import fbpa_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// Configuration registers.
	fbpa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer.
	fbpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.operation (req_data.operation),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Pool storage and arithmetic.
	fbpa_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_data  (req_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

`default_nettype wire

@@ verif/fixed_block_pool_allocator_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fixed_block_pool_allocator_checker: response checker for the pool allocator
// Follows the register writes and the accepted requests, keeps its own copy
// of the free list, the busy bits and the statistics, and compares every
// accepted response field by field with the oldest response still owed.
// ---------------------------------------------------------------------------
module fixed_block_pool_allocator_checker #(
	parameter int MAX_SLOTS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	input  logic                                req_stall,
	input  fbpa_pkg::req_t                      req_data,
	input  logic                                rsp_valid,
	input  logic                                rsp_stall,
	input  fbpa_pkg::rsp_t                      rsp_data,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic                                pready,
	input  logic [fbpa_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [fbpa_pkg::APB_DATA_W-1:0]     pwdata,
	output int unsigned                         fault_count,
	output int unsigned                         owed_count
);
	import fbpa_pkg::*;

	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	// Register copy, updated from the configuration port.
	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] max_req_q;
	logic [SIZE_W-1:0] stride_q;
	logic [CNT_W-1:0]  count_q;

	// Pool state: free-list links, busy bits, list head and statistics.
	logic [IDX_W-1:0]  link_mem [MAX_SLOTS];
	logic              busy_map [MAX_SLOTS];
	logic [IDX_W-1:0]  free_head;
	logic [CNT_W-1:0]  free_cnt;
	logic [CNT_W-1:0]  peak_load;
	logic [STAT_W-1:0] frag_sum;
	logic [STAT_W-1:0] grant_cnt;

	// Responses owed for accepted requests, oldest first.
	rsp_t              rsp_owed_q [$];
	rsp_t              owed;
	int unsigned       faults = 0;

	// Apply one request to the pool copy and return the response it yields.
	function automatic rsp_t pool_apply(input req_t item);
		rsp_t              res;
		int unsigned       slots;
		int unsigned       in_use;
		logic [IDX_W-1:0]  slot;
		logic [ADDR_W-1:0] slot_wide;
		logic [ADDR_W-1:0] stride_wide;
		logic [ADDR_W-1:0] offset;
		logic [ADDR_W-1:0] pos;
		slots = (count_q > MAX_SLOTS) ? MAX_SLOTS : count_q;
		stride_wide = stride_q;
		res = '0;
		res.success = 1'b1;
		case (item.operation)
			OP_ALLOC: begin
				if (item.request_size > max_req_q || free_cnt == '0) begin
					res.success = 1'b0;
				end else begin
					// Pop the head of the free list.
					slot = free_head;
					slot_wide = slot;
					res.slot_address = base_q + slot_wide * stride_wide;
					free_head = link_mem[slot];
					busy_map[slot] = 1'b1;
					free_cnt = free_cnt - 1'b1;
					frag_sum = frag_sum + (max_req_q - item.request_size);
					grant_cnt = grant_cnt + 1'b1;
					in_use = (slots > free_cnt) ? slots - free_cnt : 0;
					if (in_use > peak_load) begin
						peak_load = in_use;
					end
				end
			end
			OP_RELEASE: begin
				offset = item.release_address - base_q;
				if (stride_q == '0 || item.release_address < base_q) begin
					res.success = 1'b0;
				end else if (offset % stride_wide != '0) begin
					res.success = 1'b0;
				end else begin
					// Aligned address: the slot must be in range and busy.
					pos = offset / stride_wide;
					if (pos >= slots || !busy_map[pos]) begin
						res.success = 1'b0;
					end else begin
						link_mem[pos] = free_head;
						busy_map[pos] = 1'b0;
						free_cnt = free_cnt + 1'b1;
						free_head = pos[IDX_W-1:0];
					end
				end
			end
			OP_INIT: begin
				// Chain the slots in order, the last one back to slot zero.
				peak_load = '0;
				frag_sum = '0;
				grant_cnt = '0;
				for (int i = 0; i < MAX_SLOTS; i++) begin
					busy_map[i] = 1'b0;
				end
				for (int i = 0; i < slots; i++) begin
					link_mem[i] = (i + 1 < slots) ? i + 1 : 0;
				end
				free_head = '0;
				free_cnt = slots;
			end
			OP_CLEAR: begin
				peak_load = '0;
				frag_sum = '0;
				grant_cnt = '0;
			end
		endcase
		res.free_slots = free_cnt;
		res.peak_in_use = peak_load;
		res.fragmentation_total = frag_sum;
		res.allocation_total = grant_cnt;
		return res;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
			faults++;
		end
	endtask

	// Follow register writes, retire responses, then record new requests.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q = RST_BASE_ADDRESS;
			max_req_q = RST_MAX_REQUEST;
			stride_q = RST_SLOT_STRIDE;
			count_q = RST_SLOT_COUNT;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				link_mem[i] = '0;
				busy_map[i] = 1'b0;
			end
			free_head = '0;
			free_cnt = '0;
			peak_load = '0;
			frag_sum = '0;
			grant_cnt = '0;
			rsp_owed_q.delete();
			owed_count <= 0;
			fault_count <= faults;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_W-1:2])
					REG_BASE_ADDRESS: base_q = pwdata;
					REG_MAX_REQUEST:  max_req_q = pwdata[SIZE_W-1:0];
					REG_SLOT_STRIDE:  stride_q = pwdata[SIZE_W-1:0];
					REG_SLOT_COUNT:   count_q = pwdata[CNT_W-1:0];
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (rsp_owed_q.size() == 0) begin
					$display("%0t: response with no request outstanding, got %h",
						$time, rsp_data);
					faults++;
				end else begin
					owed = rsp_owed_q.pop_front();
					check_field("success", owed.success, rsp_data.success);
					check_field("slot_address", owed.slot_address, rsp_data.slot_address);
					check_field("free_slots", owed.free_slots, rsp_data.free_slots);
					check_field("peak_in_use", owed.peak_in_use, rsp_data.peak_in_use);
					check_field("fragmentation_total", owed.fragmentation_total,
						rsp_data.fragmentation_total);
					check_field("allocation_total", owed.allocation_total,
						rsp_data.allocation_total);
				end
			end
			if (req_valid && !req_stall) begin
				rsp_owed_q.push_back(pool_apply(req_data));
			end
			fault_count <= faults;
			owed_count <= rsp_owed_q.size();
		end
	end

endmodule

@@ verif/fixed_block_pool_allocator_core_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fixed_block_pool_allocator_core_tb: testbench of the block pool allocator
// Programs the pool registers, sends a directed set of requests and then
// random traffic over several pool layouts and idling patterns, and reports
// the outcome of the checker that sits beside the block.
// ---------------------------------------------------------------------------
module fixed_block_pool_allocator_core_tb;
	import fbpa_pkg::*;

	localparam int MAX_SLOTS   = 256;
	localparam int HOLD_CYCLES = 400;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req_data;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp_data;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int unsigned           fault_count;
	int unsigned           owed_count;

	// Idling controls and the pool layout currently programmed.
	int unsigned           sender_idle_pct = 0;
	int unsigned           stall_pct = 0;
	bit                    hold_off_req = 1'b0;
	logic [ADDR_W-1:0]     cur_base;
	logic [SIZE_W-1:0]     cur_max_req;
	logic [SIZE_W-1:0]     cur_stride;
	int unsigned           eff_count;

	fixed_block_pool_allocator_core #(
		.MAX_SLOTS(MAX_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	fixed_block_pool_allocator_checker #(
		.MAX_SLOTS(MAX_SLOTS)
	) checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.fault_count(fault_count),
		.owed_count(owed_count)
	);

	always #5 clk = ~clk;

	// Response side: random stalls, or one long hold-off when asked for.
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Run limit.
	initial begin
		#8_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic req_t make_req(input logic [1:0] op, input logic [SIZE_W-1:0] size,
			input logic [ADDR_W-1:0] addr);
		req_t item;
		item.operation = op;
		item.request_size = size;
		item.release_address = addr;
		return item;
	endfunction

	// Mostly allocations and releases of slot addresses, with some noise.
	function automatic req_t random_item();
		req_t              item;
		int unsigned       roll;
		int unsigned       span;
		int unsigned       k;
		logic [ADDR_W-1:0] slot_addr;
		item.operation = OP_CLEAR;
		item.request_size = $urandom;
		item.release_address = $urandom;
		roll = $urandom_range(99);
		if (roll < 45) begin
			item.operation = OP_ALLOC;
			if ($urandom_range(99) < 85) begin
				item.request_size = $urandom_range(cur_max_req);
			end
		end else if (roll < 87) begin
			item.operation = OP_RELEASE;
			// Low slots are the ones most likely to be busy.
			span = eff_count;
			if (span > 16 && $urandom_range(99) < 60) begin
				span = 16;
			end
			k = (span == 0) ? 0 : $urandom_range(span - 1);
			slot_addr = cur_base + k * cur_stride;
			case ($urandom_range(9))
				0: item.release_address = $urandom;
				1: item.release_address = slot_addr + 1'b1;
				2: item.release_address = cur_base - 1'b1;
				3: item.release_address = cur_base + eff_count * cur_stride;
				default: item.release_address = slot_addr;
			endcase
		end else if (roll < 93) begin
			item.operation = OP_INIT;
		end
		return item;
	endfunction

	// Offer one request and return at the edge where it is accepted.
	task automatic send_request(input req_t item);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		req_valid <= 1'b1;
		req_data <= item;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic run_random(input int unsigned items);
		repeat (items) send_request(random_item());
	endtask

	// Stop offering and wait until every owed response has been taken.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (owed_count != 0);
	endtask

	// Setup cycle, then access cycle; psel stays high into the next write.
	task automatic reg_write(input logic [1:0] index, input logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apb_idle();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure_pool(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] max_req,
			input logic [SIZE_W-1:0] stride, input logic [CNT_W-1:0] count);
		reg_write(REG_BASE_ADDRESS, base);
		reg_write(REG_MAX_REQUEST, max_req);
		reg_write(REG_SLOT_STRIDE, stride);
		reg_write(REG_SLOT_COUNT, count);
		apb_idle();
		cur_base = base;
		cur_max_req = max_req;
		cur_stride = stride;
		eff_count = (count > MAX_SLOTS) ? MAX_SLOTS : count;
	endtask

	// New layout and idling pattern, then a fresh pool.
	task automatic start_phase(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] max_req,
			input logic [SIZE_W-1:0] stride, input logic [CNT_W-1:0] count,
			input int unsigned idle, input int unsigned stall);
		wait_drained();
		sender_idle_pct = idle;
		stall_pct = stall;
		configure_pool(base, max_req, stride, count);
		send_request(make_req(OP_INIT, '0, '0));
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: four slots of 64 bytes at 0x1000, requests up to 100 bytes.
		configure_pool(32'h0000_1000, 16'd100, 16'd64, 9'd4);
		// Pool unusable before the first initialize.
		send_request(make_req(OP_ALLOC, 16'd10, '0));
		send_request(make_req(OP_RELEASE, '0, 32'h0000_1000));
		send_request(make_req(OP_CLEAR, '0, '0));
		send_request(make_req(OP_INIT, '0, '0));
		// Size limits, then allocate until the pool runs dry.
		send_request(make_req(OP_ALLOC, 16'd0, '0));
		send_request(make_req(OP_ALLOC, 16'd100, '0));
		send_request(make_req(OP_ALLOC, 16'd101, '0));
		send_request(make_req(OP_ALLOC, 16'hFFFF, '0));
		send_request(make_req(OP_ALLOC, 16'd50, '0));
		send_request(make_req(OP_ALLOC, 16'd99, '0));
		send_request(make_req(OP_ALLOC, 16'd1, '0));
		// Releases below the base, misaligned, out of range, good, and repeated.
		send_request(make_req(OP_RELEASE, '0, 32'h0000_0FFF));
		send_request(make_req(OP_RELEASE, '0, 32'h0000_1041));
		send_request(make_req(OP_RELEASE, '0, 32'h0000_1100));
		send_request(make_req(OP_RELEASE, '0, 32'h0000_1040));
		send_request(make_req(OP_RELEASE, '0, 32'h0000_1040));
		send_request(make_req(OP_RELEASE, '0, 32'hFFFF_FFFF));
		send_request(make_req(OP_RELEASE, '0, 32'h0000_0000));
		send_request(make_req(OP_ALLOC, 16'd7, '0));
		send_request(make_req(OP_RELEASE, '0, 32'h0000_1080));
		send_request(make_req(OP_RELEASE, '0, 32'h0000_1000));
		send_request(make_req(OP_CLEAR, '0, '0));
		send_request(make_req(OP_ALLOC, 16'd64, '0));
		send_request(make_req(OP_INIT, '0, '0));

		// Small pool, no idling; the response side holds off to fill the block.
		start_phase(32'h0001_0000, 16'd64, 16'd64, 9'd8, 0, 0);
		hold_off_req = 1'b1;
		run_random(140);
		// Full pool with widest stride near the top of the address space.
		start_phase(32'hFFFF_0000, 16'hFFFF, 16'hFFFF, 9'd256, 54, 0);
		run_random(140);
		// Single one-byte slot at address zero.
		start_phase(32'h0000_0000, 16'd1, 16'd1, 9'd1, 0, 54);
		run_random(100);
		// Random layout, then the count shrinks below the load without an initialize.
		start_phase($urandom, $urandom_range(65535, 1), $urandom_range(65535, 1),
			$urandom_range(40, 2), 37, 37);
		run_random(80);
		wait_drained();
		reg_write(REG_SLOT_COUNT, 32'd3);
		apb_idle();
		eff_count = 3;
		run_random(60);
		// Count above the slot limit, zero stride and zero request size.
		start_phase(32'h8000_0000, 16'd0, 16'd0, 9'd300, 0, 0);
		run_random(60);
		// Empty pool at the highest base address.
		start_phase(32'hFFFF_FFFF, 16'h0100, 16'd16, 9'd0, 54, 0);
		run_random(40);
		// Widest count field and a stride that is not a power of two.
		start_phase(32'h1234_5670, 16'd1000, 16'd48, 9'd511, 0, 54);
		run_random(180);

		wait_drained();
		repeat (300) @(posedge clk);
		if (fault_count == 0 && owed_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
